// ===== src/serial_motion_command_parser_defines.svh =====
// assertion macros for the serial motion command parser
`ifndef SERIAL_MOTION_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_MOTION_COMMAND_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked assertion, disabled while reset is asserted
`define SMCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion, also checked during reset
`define SMCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMCP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/smcp_pkg.sv =====
// shared types and constants of the serial motion command parser
`default_nettype none

package smcp_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActionW = 2;
  localparam int unsigned AmountW = 32;
  localparam int unsigned RegW    = 16;
  localparam int unsigned RegIdxW = 1;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned TokLenW = 3;
  localparam int unsigned OutDataW = 40;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] REG_STEER_MIN = 1'd0;
  localparam logic [RegIdxW-1:0] REG_STEER_MAX = 1'd1;

  // configuration reset values
  localparam logic [RegW-1:0] SteerMinReset = 16'd85;
  localparam logic [RegW-1:0] SteerMaxReset = 16'd240;

  // parse phases
  localparam logic [PhaseW-1:0] PH_BEFORE = 3'd0;
  localparam logic [PhaseW-1:0] PH_TOKEN  = 3'd1;
  localparam logic [PhaseW-1:0] PH_GAP    = 3'd2;
  localparam logic [PhaseW-1:0] PH_SIGN   = 3'd3;
  localparam logic [PhaseW-1:0] PH_DIGITS = 3'd4;
  localparam logic [PhaseW-1:0] PH_DONE   = 3'd5;
  localparam logic [PhaseW-1:0] PH_FAIL   = 3'd6;

  // action codes
  localparam logic [ActionW-1:0] ACT_NONE  = 2'd0;
  localparam logic [ActionW-1:0] ACT_FWD   = 2'd1;
  localparam logic [ActionW-1:0] ACT_BCK   = 2'd2;
  localparam logic [ActionW-1:0] ACT_STEER = 2'd3;

  // special characters
  localparam logic [ByteW-1:0] CH_CLEAR = 8'h3A;  // ':'
  localparam logic [ByteW-1:0] CH_END   = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;

  // command names, first character in the lowest byte
  localparam logic [3*ByteW-1:0] NameFwd = {8'h44, 8'h57, 8'h46};  // FWD
  localparam logic [3*ByteW-1:0] NameBck = {8'h4B, 8'h43, 8'h42};  // BCK
  localparam logic [3*ByteW-1:0] NameLft = {8'h54, 8'h46, 8'h4C};  // LFT

  // one result item
  typedef struct packed {
    logic                       steer_rejected;
    logic                       malformed;
    logic                       overflow;
    logic signed [AmountW-1:0]  amount;
    logic [ActionW-1:0]         action;
  } result_t;

endpackage

`default_nettype wire

// ===== src/serial_motion_command_parser.sv =====
// serial motion command parser: byte stream in, command items out
//
// Usage: received serial bytes enter on the s_axis channel, one byte per item.
// ':' clears the line, ';' ends it and emits one command item on m_axis; a
// byte that finds the line already MAX_LINE-1 bytes long also emits an item
// with the overflow flag set. All other bytes emit nothing.
// The parse state and the result are computed from the incoming byte in the
// cycle it is accepted; the result item is then registered in the output
// register, or in the skid register if that one is held. One byte per cycle
// while s_axis_tready is high; every byte reads and updates the single parse state.
// A two-entry result buffer (output register plus skid register) sits on the
// master side, so input keeps flowing while one result waits; s_axis_tready
// drops only when both entries hold results and stays low until m_axis takes
// one.
// Reset clears the line, the result buffer and the parse state but for the
// token characters, and loads the steering limits with 85 and 240. The limits
// may be rewritten on the cfg port while the block is idle.
`default_nettype none

`include "serial_motion_command_parser_defines.svh"

module serial_motion_command_parser #(
  parameter int unsigned MAX_LINE = 20
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [smcp_pkg::RegIdxW-1:0]      cfg_idx_i,
  input  wire logic [smcp_pkg::RegW-1:0]         cfg_wdata_i,
  // byte input
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [smcp_pkg::ByteW-1:0]        s_axis_tdata,   // rx_byte[7:0]
  // command output
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // action[1:0], amount[33:2], overflow[34], malformed[35], steer_rejected[36], zeros
  output logic [smcp_pkg::OutDataW-1:0]          m_axis_tdata
);

  import smcp_pkg::*;

  localparam int unsigned LineW = $clog2(MAX_LINE);
  localparam logic [LineW-1:0] LineLast = LineW'(MAX_LINE - 1);
  localparam int unsigned MulW = AmountW + 4;

  // configuration registers
  logic [RegW-1:0] steer_min_q, steer_max_q;

  // parse state
  logic [LineW-1:0]       line_count_q, line_count_d;
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [ByteW-1:0]       tok_q [3];
  logic [ByteW-1:0]       tok_d [3];
  logic [TokLenW-1:0]     tok_len_q, tok_len_d;
  logic [AmountW-1:0]     acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic                   digits_q, digits_d;

  // state seen by the current byte, after an overflow clear
  logic [LineW-1:0]       cur_count;
  logic [PhaseW-1:0]      cur_phase;
  logic [TokLenW-1:0]     cur_tok_len;
  logic [AmountW-1:0]     cur_acc;
  logic                   cur_neg;
  logic                   cur_digits;

  // byte classification and digit step
  logic [ByteW-1:0]       rx;
  logic                   ovf, is_space, is_digit, is_sign;
  logic [MulW-1:0]        acc_ext, acc_x10, acc_limit;
  logic [AmountW-1:0]     acc_sat;
  logic                   s_fire, m_fire;

  // line finish
  logic                   tok_fwd, tok_bck, tok_lft, steer_bad;
  logic                   res_valid;
  result_t                res;

  // result buffer
  logic                   out_valid_q, skid_valid_q;
  result_t                out_q, skid_q;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign rx     = s_axis_tdata;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_min_q <= SteerMinReset;
      steer_max_q <= SteerMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEER_MIN: steer_min_q <= cfg_wdata_i;
        REG_STEER_MAX: steer_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // overflow clears the line before the byte is handled
  assign ovf         = (line_count_q == LineLast);
  assign cur_count   = ovf ? '0 : line_count_q;
  assign cur_phase   = ovf ? PH_BEFORE : phase_q;
  assign cur_tok_len = ovf ? '0 : tok_len_q;
  assign cur_acc     = ovf ? '0 : acc_q;
  assign cur_neg     = ovf ? 1'b0 : neg_q;
  assign cur_digits  = ovf ? 1'b0 : digits_q;

  // byte classes
  assign is_space = (rx == CH_SPACE) || ((rx >= CH_TAB) && (rx <= CH_CR));
  assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
  assign is_sign  = (rx == CH_PLUS) || (rx == CH_MINUS);

  // accumulate one decimal digit with saturation
  assign acc_ext   = MulW'(cur_acc);
  assign acc_x10   = (acc_ext << 3) + (acc_ext << 1) + MulW'(rx - CH_ZERO);
  assign acc_limit = cur_neg ? MulW'(64'd2147483648) : MulW'(64'd2147483647);
  assign acc_sat   = (acc_x10 > acc_limit) ? acc_limit[AmountW-1:0] : acc_x10[AmountW-1:0];

  // next parse state
  always_comb begin
    line_count_d = cur_count;
    phase_d      = cur_phase;
    tok_d        = tok_q;
    tok_len_d    = cur_tok_len;
    acc_d        = cur_acc;
    neg_d        = cur_neg;
    digits_d     = cur_digits;
    if ((rx == CH_CLEAR) || (rx == CH_END)) begin
      line_count_d = '0;
      phase_d      = PH_BEFORE;
      tok_len_d    = '0;
      acc_d        = '0;
      neg_d        = 1'b0;
      digits_d     = 1'b0;
    end else begin
      line_count_d = cur_count + LineW'(1);
      unique case (cur_phase)
        PH_BEFORE: begin
          if (rx == CH_NUL) begin
            phase_d = PH_FAIL;
          end else if (!is_space) begin
            tok_d[0]  = rx;
            tok_len_d = TokLenW'(1);
            phase_d   = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (rx == CH_NUL) begin
            phase_d = PH_FAIL;
          end else if (is_space) begin
            phase_d = PH_GAP;
          end else if (cur_tok_len < TokLenW'(3)) begin
            tok_d[cur_tok_len[1:0]] = rx;
            tok_len_d = cur_tok_len + TokLenW'(1);
          end else begin
            tok_len_d = TokLenW'(4);
          end
        end
        PH_GAP: begin
          if (is_space) begin
            phase_d = PH_GAP;
          end else if (is_sign) begin
            neg_d   = (rx == CH_MINUS);
            phase_d = PH_SIGN;
          end else if (is_digit) begin
            acc_d    = acc_sat;
            digits_d = 1'b1;
            phase_d  = PH_DIGITS;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            acc_d    = acc_sat;
            digits_d = 1'b1;
            phase_d  = PH_DIGITS;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_d    = acc_sat;
            digits_d = 1'b1;
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // token match against the command names
  assign tok_fwd = (cur_tok_len == TokLenW'(3)) && ({tok_q[2], tok_q[1], tok_q[0]} == NameFwd);
  assign tok_bck = (cur_tok_len == TokLenW'(3)) && ({tok_q[2], tok_q[1], tok_q[0]} == NameBck);
  assign tok_lft = (cur_tok_len == TokLenW'(3)) && ({tok_q[2], tok_q[1], tok_q[0]} == NameLft);
  assign steer_bad = (cur_neg && (cur_acc != '0))
                   || (cur_acc < AmountW'(steer_min_q))
                   || (cur_acc > AmountW'(steer_max_q));

  // result item for ';' or overflow
  always_comb begin
    res          = '0;
    res.overflow = ovf;
    res_valid    = s_fire && (ovf || (rx == CH_END));
    if (rx == CH_END) begin
      if (cur_digits) begin
        res.amount = cur_neg ? AmountW'(-cur_acc) : cur_acc;
      end
      if (!cur_digits) begin
        res.malformed = 1'b1;
      end else if (tok_fwd) begin
        res.action = ACT_FWD;
      end else if (tok_bck) begin
        res.action = ACT_BCK;
      end else if (tok_lft) begin
        if (steer_bad) begin
          res.steer_rejected = 1'b1;
        end else begin
          res.action = ACT_STEER;
        end
      end else begin
        res.malformed = 1'b1;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      phase_q      <= PH_BEFORE;
      tok_len_q    <= '0;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      digits_q     <= 1'b0;
    end else if (s_fire) begin
      line_count_q <= line_count_d;
      phase_q      <= phase_d;
      tok_len_q    <= tok_len_d;
      acc_q        <= acc_d;
      neg_q        <= neg_d;
      digits_q     <= digits_d;
    end
  end

  // token characters carry no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      tok_q <= tok_d;
    end
  end

  // result buffer valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !m_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !m_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

  // checks
  `SMCP_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `SMCP_ASSERT_ALWAYS(a_line_bound, clk_i, !rst_ni || (line_count_q <= LineLast), "line count past its bound")
  `SMCP_ASSERT(a_action_clean, clk_i, rst_ni, (out_valid_q && (out_q.action != ACT_NONE)) |-> (!out_q.malformed && !out_q.steer_rejected && !out_q.overflow), "action item carries error flag")
  `SMCP_ASSERT(a_no_lost_result, clk_i, rst_ni, (skid_valid_q && !m_fire) |=> skid_valid_q, "pending result dropped")

endmodule

`default_nettype wire
